/* rtl/core/first_fit_extent_allocator_defines.svh */
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define FFEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next edge.
`define FFEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ffea_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ffea_pkg;
  localparam int unsigned DESC_DEFAULT = 64;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSIZE = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_NOSPARE = 2'd3;

  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,   // rebuild: chain spares, one entry per cycle
    S_IDLE,
    S_RD,     // read of cur issued
    S_CHK,    // cur data available
    S_ALINK,  // write back prev link for an emptied extent
    S_FCUR,   // read cur where the free walk stopped
    S_FSPR,   // latch cur data, read spare head
    S_FMERGE, // merge or place the returned block
    S_FLINK,  // second link write of a free
    S_DONE
  } state_t;
endpackage
`default_nettype wire

/* rtl/core/first_fit_extent_allocator.sv */
// Result timing: a rejected or zero-size item goes straight to S_DONE; else the walk
// visits N extents (N <= DESCRIPTORS), each one read from memory (S_RD) and then
// compared (S_CHK), followed by the alloc or free tail states and S_DONE.
// Flow: one item in flight; the next can be taken from the cycle after the result is
// loaded, and a stalled result holds the block. Reset (sync, rst_n low) or a config
// write rebuilds one free extent over the pool, no item taken.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_extent_allocator #(
  parameter int unsigned DESCRIPTORS = ffea_pkg::DESC_DEFAULT
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [71:0] in_tdata,  // req_size[31:0], req_addr[63:32], zero pad
  input  wire         in_tuser,  // action
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata, // granted_addr[31:0], status[33:32], free_bytes[65:34]
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_wdata
);
  import ffea_pkg::*;
  `include "first_fit_extent_allocator_defines.svh"

  localparam int AW = $clog2(DESCRIPTORS);
  localparam int LW = $clog2(DESCRIPTORS + 1);
  localparam logic [LW-1:0] END_MARK = LW'(DESCRIPTORS);

  // descriptor memories: start, length, link; one read port each, shared address
  logic [31:0]   mem_start [DESCRIPTORS];
  logic [31:0]   mem_len   [DESCRIPTORS];
  logic [LW-1:0] mem_link  [DESCRIPTORS];
  logic [31:0]   rd_start, rd_len;
  logic [LW-1:0] rd_link;

  state_t state_r, state_nxt;
  logic [31:0] base_r, size_r, total_r;
  logic [LW-1:0] head_r, spare_r, prev_r, cur_r, init_r, steps_r;
  logic act_r;
  logic [31:0] rsize_r, raddr_r;
  logic [31:0] pstart_r, plen_r;            // prev extent data
  logic [31:0] cstart_r, clen_r;            // cur extent data at walk stop
  logic [LW-1:0] clink_r;
  logic [LW-1:0] plink_r;                   // link of an emptied extent
  logic [LW-1:0] newt_r;                    // descriptor taken for a new extent
  logic [31:0] gaddr_r;
  logic [1:0] stat_r;
  logic ovld_r, ovld_nxt;
  logic [71:0] odata_r;

  // memory port control
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic ws_en, wl_en, wk_en;
  logic [AW-1:0] w_addr;
  logic [31:0] ws_d, wl_d;
  logic [LW-1:0] wk_d;

  logic cur_end, walk_end, fits, stop_free;
  logic jp, jn;
  logic [31:0] pend;
  logic accept, bad_req, skip_req, load;

  always_ff @(posedge clk) begin
    if (ws_en) mem_start[w_addr] <= ws_d;
    if (wl_en) mem_len[w_addr] <= wl_d;
    if (wk_en) mem_link[w_addr] <= wk_d;
    if (rd_en) begin
      rd_start <= mem_start[rd_addr];
      rd_len   <= mem_len[rd_addr];
      rd_link  <= mem_link[rd_addr];
    end
  end

  assign cur_end   = (cur_r >= END_MARK);
  assign walk_end  = cur_end || (steps_r == END_MARK);
  assign fits      = rd_len >= rsize_r;
  assign stop_free = raddr_r < rd_start;
  assign pend      = pstart_r + plen_r;
  assign jp        = (prev_r != END_MARK) && (pend == raddr_r);
  assign jn        = !cur_end && ((raddr_r + rsize_r) == cstart_r);

  assign in_tready = (state_r == S_IDLE) && !cfg_we;
  assign accept    = in_tvalid && in_tready;
  assign bad_req   = (in_tuser == ACT_ALLOC) &&
                     (in_tdata[31:0] == 32'd0 || in_tdata[31:0] > total_r);
  assign skip_req  = (in_tuser == ACT_FREE) && (in_tdata[31:0] == 32'd0);
  assign load      = (state_r == S_DONE) && (!ovld_r || out_tready);
  assign ovld_nxt  = load ? 1'b1 : (out_tready ? 1'b0 : ovld_r);

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (init_r == END_MARK - 1'b1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) state_nxt = (bad_req || skip_req) ? S_DONE : S_RD;
      end
      S_RD: begin
        if (walk_end) state_nxt = (act_r == ACT_ALLOC) ? S_DONE : S_FCUR;
        else state_nxt = S_CHK;
      end
      S_CHK: begin
        if (act_r == ACT_ALLOC) begin
          if (fits) state_nxt = (rd_len == rsize_r) ? S_ALINK : S_DONE;
          else state_nxt = S_RD;
        end else begin
          state_nxt = stop_free ? S_FCUR : S_RD;
        end
      end
      S_ALINK:  state_nxt = S_DONE;
      S_FCUR:   state_nxt = S_FSPR;
      S_FSPR:   state_nxt = S_FMERGE;
      S_FMERGE: begin
        if (jp || jn) state_nxt = (jp && jn) ? S_FLINK : S_DONE;
        else state_nxt = (spare_r == END_MARK) ? S_DONE : S_FLINK;
      end
      S_FLINK:  state_nxt = S_DONE;
      S_DONE:   if (load) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
    if (cfg_we) state_nxt = S_INIT;
  end

  // memory port drive
  always_comb begin
    rd_en = 1'b0; rd_addr = cur_r[AW-1:0];
    ws_en = 1'b0; wl_en = 1'b0; wk_en = 1'b0;
    w_addr = cur_r[AW-1:0]; ws_d = raddr_r; wl_d = rd_len - rsize_r; wk_d = spare_r;
    case (state_r)
      S_INIT: begin
        w_addr = init_r[AW-1:0];
        wk_en = 1'b1;
        if (init_r == '0) begin
          ws_en = 1'b1; wl_en = 1'b1; ws_d = base_r; wl_d = size_r; wk_d = END_MARK;
        end else begin
          wk_d = init_r + 1'b1;
        end
      end
      S_RD: rd_en = !walk_end;
      S_CHK: begin
        // carve from the top; an emptied extent goes to the spare chain
        if (act_r == ACT_ALLOC && fits) begin
          wl_en = 1'b1;
          if (rd_len == rsize_r) wk_en = 1'b1;
        end
      end
      S_ALINK: begin
        w_addr = prev_r[AW-1:0]; wk_d = plink_r;
        wk_en = (prev_r != END_MARK);
      end
      S_FCUR: rd_en = !cur_end;
      S_FSPR: begin
        // fetch the spare head's link for a possible new extent
        rd_addr = spare_r[AW-1:0]; rd_en = (spare_r != END_MARK);
      end
      S_FMERGE: begin
        if (jp) begin
          w_addr = prev_r[AW-1:0]; wl_en = 1'b1; wl_d = plen_r + rsize_r;
          if (jn) begin
            wl_d = plen_r + rsize_r + clen_r;
            wk_en = 1'b1; wk_d = clink_r;
          end
        end else if (jn) begin
          ws_en = 1'b1; wl_en = 1'b1; wl_d = clen_r + rsize_r;
        end else if (spare_r != END_MARK) begin
          w_addr = spare_r[AW-1:0]; ws_en = 1'b1; wl_en = 1'b1; wk_en = 1'b1;
          wl_d = rsize_r; wk_d = cur_r;
        end
      end
      S_FLINK: begin
        if (jp && jn) begin
          // join both: dropped cur returns to spare chain
          wk_en = 1'b1;
        end else begin
          w_addr = prev_r[AW-1:0]; wk_d = newt_r;
          wk_en = (prev_r != END_MARK);
        end
      end
      default: ;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; base_r <= '0; size_r <= '0; total_r <= '0;
      init_r <= '0; head_r <= '0; spare_r <= LW'(1); steps_r <= '0; ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r <= ovld_nxt;
      case (state_r)
        S_INIT: begin
          head_r <= '0; spare_r <= LW'(1);
          total_r <= size_r;
        end
        S_IDLE: begin
          if (accept) begin
            act_r <= in_tuser; rsize_r <= in_tdata[31:0]; raddr_r <= in_tdata[63:32];
            prev_r <= END_MARK; cur_r <= head_r; steps_r <= '0;
            gaddr_r <= '0;
            stat_r <= bad_req ? ST_BADSIZE : ST_OK;
          end
        end
        S_RD: if (walk_end && act_r == ACT_ALLOC) stat_r <= ST_NOFIT;
        S_CHK: begin
          if (act_r == ACT_ALLOC) begin
            if (fits) begin
              total_r <= total_r - rsize_r;
              gaddr_r <= rd_start + (rd_len - rsize_r);
              if (rd_len == rsize_r) begin
                plink_r <= rd_link; spare_r <= cur_r;
                if (prev_r == END_MARK) head_r <= rd_link;
              end
            end else begin
              prev_r <= cur_r; cur_r <= rd_link; steps_r <= steps_r + 1'b1;
            end
          end else if (!stop_free) begin
            prev_r <= cur_r; cur_r <= rd_link; steps_r <= steps_r + 1'b1;
            pstart_r <= rd_start; plen_r <= rd_len;
          end
        end
        S_FSPR: begin
          cstart_r <= rd_start; clen_r <= rd_len; clink_r <= rd_link;
        end
        S_FMERGE: begin
          if (jp || jn) total_r <= total_r + rsize_r;
          else if (spare_r == END_MARK) stat_r <= ST_NOSPARE;
          else begin
            total_r <= total_r + rsize_r;
            spare_r <= rd_link;
            newt_r <= spare_r;
            if (prev_r == END_MARK) head_r <= spare_r;
          end
        end
        S_FLINK: if (jp && jn) spare_r <= cur_r;
        default: ;
      endcase
      if (cfg_we) begin
        if (cfg_index == CFG_POOL_BASE) base_r <= cfg_wdata;
        else size_r <= cfg_wdata;
      end
      if (cfg_we) init_r <= '0;
      else if (state_r == S_INIT) init_r <= init_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      odata_r <= {6'd0, total_r, stat_r, gaddr_r};
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  `FFEA_ASSERT(a_no_ready_busy, !(in_tready && state_r != S_IDLE), "ready outside idle")
  `FFEA_ASSERT(a_steps_bound, steps_r <= END_MARK, "walk exceeded bound")
  `FFEA_ASSERT_NEXT(a_accept_leaves_idle, in_tvalid && in_tready && !cfg_we,
                    state_r != S_IDLE, "accepted item not started")
  `FFEA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "result dropped while stalled")
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
  logic [31:0] granted;
  logic [1:0]  status;
  logic [31:0] free_bytes;
} grant_t;

// Predicts the free-extent list and checks each granted item against it.
class extent_scoreboard;
  localparam int DESC = 64;
  localparam int ENDM = 64;

  logic [31:0] base_reg, size_reg;
  logic [31:0] ext_start [DESC];
  logic [31:0] ext_len   [DESC];
  int          link      [DESC];
  int          head, spare;
  logic [31:0] total;
  grant_t      awaited [$];
  int          errors;

  function new();
    base_reg = '0;
    size_reg = '0;
    errors   = 0;
    foreach (ext_start[i]) begin
      ext_start[i] = '0;
      ext_len[i]   = '0;
    end
    rebuild();
  endfunction

  // one extent over the whole pool, all other descriptors spare
  function void rebuild();
    ext_start[0] = base_reg;
    ext_len[0]   = size_reg;
    link[0]      = ENDM;
    for (int i = 1; i < DESC; i++) link[i] = i + 1;
    head  = 0;
    spare = 1;
    total = size_reg;
  endfunction

  function void write_reg(logic idx, logic [31:0] val);
    if (idx == ffea_pkg::CFG_POOL_BASE) base_reg = val;
    else size_reg = val;
    rebuild();
  endfunction

  function void set_link(int prev, int target);
    if (prev == ENDM) head = target;
    else link[prev] = target;
  endfunction

  function logic [1:0] carve(logic [31:0] size, output logic [31:0] granted);
    int prev, cur, steps;
    prev = ENDM;
    cur = head;
    steps = 0;
    granted = '0;
    if (size == 0 || size > total) return ffea_pkg::ST_BADSIZE;
    while (cur < ENDM && steps < DESC) begin
      if (ext_len[cur] >= size) begin
        total = total - size;
        ext_len[cur] = ext_len[cur] - size;
        granted = ext_start[cur] + ext_len[cur];
        if (ext_len[cur] == 0) begin
          set_link(prev, link[cur]);
          link[cur] = spare;
          spare = cur;
        end
        return ffea_pkg::ST_OK;
      end
      prev = cur;
      cur = link[cur];
      steps++;
    end
    return ffea_pkg::ST_NOFIT;
  endfunction

  function logic [1:0] give_back(logic [31:0] addr, logic [31:0] size);
    int prev, cur, steps, t;
    logic [31:0] prev_end, blk_end;
    logic jp, jn;
    prev = ENDM;
    cur = head;
    steps = 0;
    if (size == 0) return ffea_pkg::ST_OK;
    while (cur < ENDM && steps < DESC) begin
      if (addr < ext_start[cur]) break;
      prev = cur;
      cur = link[cur];
      steps++;
    end
    if (cur >= ENDM) cur = ENDM;
    prev_end = (prev != ENDM) ? ext_start[prev] + ext_len[prev] : '0;
    blk_end = addr + size;
    jp = prev != ENDM && prev_end == addr;
    jn = cur != ENDM && blk_end == ext_start[cur];
    if (jp && jn) begin
      ext_len[prev] = ext_len[prev] + size + ext_len[cur];
      link[prev] = link[cur];
      link[cur] = spare;
      spare = cur;
    end else if (jp) begin
      ext_len[prev] = ext_len[prev] + size;
    end else if (jn) begin
      ext_start[cur] = addr;
      ext_len[cur] = ext_len[cur] + size;
    end else begin
      t = spare;
      if (t >= ENDM) return ffea_pkg::ST_NOSPARE;
      spare = link[t];
      ext_start[t] = addr;
      ext_len[t] = size;
      link[t] = cur;
      set_link(prev, t);
    end
    total = total + size;
    return ffea_pkg::ST_OK;
  endfunction

  // accepted input item: predict and queue its result
  function grant_t note(logic act, logic [31:0] size, logic [31:0] addr);
    grant_t g;
    logic [31:0] gr;
    gr = '0;
    if (act == ffea_pkg::ACT_ALLOC) g.status = carve(size, gr);
    else g.status = give_back(addr, size);
    g.granted = (g.status == ffea_pkg::ST_OK) ? gr : '0;
    g.free_bytes = total;
    awaited.push_back(g);
    return g;
  endfunction

  task report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task check(logic [71:0] d);
    grant_t g;
    if (awaited.size() == 0) begin
      report($sformatf("unexpected item %h", d));
      return;
    end
    g = awaited.pop_front();
    if (d[31:0] !== g.granted)
      report($sformatf("granted_addr %h, want %h", d[31:0], g.granted));
    if (d[33:32] !== g.status)
      report($sformatf("status %0d, want %0d", d[33:32], g.status));
    if (d[65:34] !== g.free_bytes)
      report($sformatf("free_bytes %h, want %h", d[65:34], g.free_bytes));
  endtask
endclass

module tb;
  import ffea_pkg::*;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] size;
  } block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  int     in_idle, out_idle;
  bit     hold_out;
  block_t held [$];
  extent_scoreboard sb;

  first_fit_extent_allocator uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (500) @(posedge clk);
        hold_out = 0;
      end
      out_tready <= ($urandom_range(99) >= out_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  // offer one item and wait for its acceptance
  task automatic send(logic act, logic [31:0] size, logic [31:0] addr);
    grant_t g;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {8'h00, addr, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    g = sb.note(act, size, addr);
    if (act == ACT_ALLOC && g.status == ST_OK) held.push_back('{g.granted, size});
    if ($urandom_range(99) < in_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic new_pool(logic [31:0] b, logic [31:0] s);
    drain();
    write_cfg(CFG_POOL_BASE, b);
    write_cfg(CFG_POOL_SIZE, s);
    cfg_we <= 1'b0;
    held.delete();
  endtask

  // mostly real alloc/free traffic, some noise
  task automatic workload(int n);
    int r, k;
    block_t b;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 48) begin
        if ($urandom_range(9) == 0) send(ACT_ALLOC, $urandom, $urandom);
        else send(ACT_ALLOC, $urandom_range(1, 64), $urandom);
      end else if (r < 88 && held.size() != 0) begin
        k = $urandom_range(held.size() - 1);
        b = held[k];
        held.delete(k);
        if (b.size > 1 && $urandom_range(3) == 0) begin
          // return the front part only, keep the tail
          send(ACT_FREE, b.size / 2, b.addr);
          held.push_back('{b.addr + b.size / 2, b.size - b.size / 2});
        end else begin
          send(ACT_FREE, b.size, b.addr);
        end
      end else if (r < 94) begin
        send(ACT_FREE, $urandom, $urandom);
      end else begin
        send(1'($urandom_range(1)), 0, $urandom);
      end
    end
  endtask

  // many small frees to take up spare descriptors
  task automatic fragment(logic [31:0] b);
    for (int i = 0; i < 80; i++) send(ACT_ALLOC, 2, 0);
    for (int i = 0; i < 80; i += 2) send(ACT_FREE, 2, b + 4 * i);
    held.delete();
  endtask

  initial begin
    sb = new();
    in_idle = 36;
    out_idle = 49;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pool after reset, then basic cases
    send(ACT_ALLOC, 1, 0);
    send(ACT_FREE, 32'h10, 32'h0);
    send(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    new_pool(32'h1000, 32'h100);
    send(ACT_ALLOC, 0, 0);
    send(ACT_ALLOC, 32'h101, 0);
    send(ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_ALLOC, 32'h80, 0);
    send(ACT_ALLOC, 32'h40, 0);
    send(ACT_FREE, 32'h80, 32'h1080);
    send(ACT_ALLOC, 32'hA0, 0);
    send(ACT_FREE, 32'h40, 32'h1040);
    send(ACT_FREE, 0, 32'h1234);
    send(ACT_ALLOC, 32'h10, 0);
    send(ACT_ALLOC, 32'h20, 0);
    send(ACT_FREE, 32'h10, 32'h10F0);
    send(ACT_FREE, 32'h20, 32'h10D0);
    send(ACT_FREE, 32'h10, 32'h1100);
    new_pool(32'hFFFF_FFF0, 32'h40);
    send(ACT_ALLOC, 32'h30, 0);
    send(ACT_FREE, 32'h30, 32'h0000_0020);
    send(ACT_FREE, 32'h8, 32'hFFFF_FFF8);

    // random, receiver idles more
    new_pool(32'h2000, 32'h1000);
    fragment(32'h2000);
    workload(110);
    hold_out = 1;
    workload(110);
    new_pool(32'h0, 32'hFFFF_FFFF);
    workload(110);

    // random, sender idles more
    in_idle = 49;
    out_idle = 36;
    new_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    workload(110);
    new_pool(32'h8000_0000, 32'h200);
    fragment(32'h8000_0000);
    workload(110);
    new_pool(32'h0, 32'h0);
    workload(60);

    // no idling
    in_idle = 0;
    out_idle = 0;
    new_pool($urandom, 32'h4000);
    workload(250);
    new_pool(32'hFFFF_FF00, 32'h1000);
    workload(200);

    drain();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire
